/* hdl/pad_pkg.sv */
// Shared widths, register indexes and reset values for the PID duty block.
`timescale 1ns / 1ps
`default_nettype none
package pad_pkg;

  // Field widths
  localparam int SETPOINT_W = 13;
  localparam int DUTY_W     = 7;
  localparam int CENTI_W    = 9;
  localparam int EFFORT_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 15;

  // Internal Q10 widths
  localparam int MEAS_W  = 13;
  localparam int ERR_W   = 14;
  localparam int ESUM_W  = 15;
  localparam int INTEG_W = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EFFORT_LIMIT = 3'd4;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 16'd3840;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST   = 16'd77;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST   = 16'd1280;
  localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST  = 15'd25600;
  localparam logic [LIMIT_W-1:0] EFFORT_LIMIT_RST = 15'd25600;

  // Duty mapping: floor((2*eff + 50*1024) / 1024), saturated
  localparam logic signed [17:0] DUTY_BIAS = 18'sd51200;
  localparam logic [DUTY_W-1:0]  DUTY_MAX  = 7'd100;
  localparam logic [DUTY_W-1:0]  DUTY_MID  = 7'd50;

  // Measurement in hundredths
  localparam logic signed [19:0] CENTI_SCALE = 20'sd100;
  localparam logic signed [19:0] Q10_ROUND   = 20'sd1023;

endpackage
`default_nettype wire

/* hdl/pid_adc_to_pwm_duty.sv */
// Top level: fixed-point PID controller from ADC sample to PWM duty.
`timescale 1ns / 1ps
`default_nettype none
// Takes one ADC sample and Q10 setpoint per transfer and returns one result
// (duty percent, measurement in hundredths, clamped Q10 effort). The block
// sustains one item per clock cycle while out_ready is held high; an input
// transfer loads the input register, and the result register loads from it
// through one combinational pass of parallel gain multiplies, integral clamp
// and effort clamp once it is empty or being drained. The integrator
// and previous error update as an item enters the result register, so the
// next item sees them at once. Configuration writes are always ready and
// must happen only while no item is in flight; indexes above 4 are ignored.
module pid_adc_to_pwm_duty #(
  parameter int ADC_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [ADC_BITS-1:0]                    in_adc_sample,
  input  logic signed [pad_pkg::SETPOINT_W-1:0]  in_setpoint,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [pad_pkg::DUTY_W-1:0]             out_pwm_duty,
  output logic signed [pad_pkg::CENTI_W-1:0]     out_measured_centi,
  output logic signed [pad_pkg::EFFORT_W-1:0]    out_control_effort,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pad_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [pad_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import pad_pkg::*;

  localparam int DIFF_W = ADC_BITS + 1;
  localparam int WIDE_W = ADC_BITS + 14;
  localparam int UP_SH  = (ADC_BITS < 12) ? 12 - ADC_BITS : 0;
  localparam int DN_SH  = (ADC_BITS > 12) ? ADC_BITS - 12 : 0;
  localparam logic [ADC_BITS-1:0] ADC_MID = {1'b0, {(ADC_BITS-1){1'b1}}};

  // Configuration registers
  logic [GAIN_W-1:0]  kp_r, ki_r, kd_r;
  logic [LIMIT_W-1:0] ilim_r, elim_r;

  // Input stage
  logic                         s_valid_r;
  logic [ADC_BITS-1:0]          adc_r;
  logic signed [SETPOINT_W-1:0] sp_r;

  // Controller state
  logic signed [ERR_W-1:0]   last_err_r;
  logic signed [INTEG_W-1:0] int_sum_r;

  // Result register
  logic                       out_valid_r;
  logic [DUTY_W-1:0]          duty_r;
  logic signed [CENTI_W-1:0]  centi_r;
  logic signed [EFFORT_W-1:0] eff_r;

  logic adv;

  // Datapath
  logic signed [DIFF_W-1:0]   adc_diff;
  logic signed [WIDE_W-1:0]   meas_wide;
  logic signed [MEAS_W-1:0]   meas;
  logic signed [ERR_W-1:0]    err;
  logic signed [ESUM_W-1:0]   esum, ediff;
  logic signed [30:0]         i_prod;
  logic signed [30:0]         p_prod;
  logic signed [31:0]         d_prod;
  logic signed [31:0]         pd_sum;
  logic signed [23:0]         integ_raw, ilim_s;
  logic signed [INTEG_W-1:0]  integ_nxt;
  logic signed [24:0]         eff_raw, elim_s;
  logic signed [EFFORT_W-1:0] eff_nxt;
  logic signed [17:0]         dsum, dq;
  logic [DUTY_W-1:0]          duty_nxt;
  logic signed [19:0]         cprod, cadj, cq;
  logic signed [CENTI_W-1:0]  centi_nxt;

  assign adv       = s_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s_valid_r || adv;
  assign cfg_ready = 1'b1;

  assign out_valid          = out_valid_r;
  assign out_pwm_duty       = duty_r;
  assign out_measured_centi = centi_r;
  assign out_control_effort = eff_r;

  always_comb begin
    // Center and rescale the sample to Q10; floor when the converter is wider
    adc_diff  = $signed({1'b0, adc_r}) - $signed({1'b0, ADC_MID});
    meas_wide = (WIDE_W'(adc_diff) <<< UP_SH) >>> DN_SH;
    meas      = meas_wide[MEAS_W-1:0];

    err   = ERR_W'(sp_r) - ERR_W'(meas);
    esum  = ESUM_W'(err) + ESUM_W'(last_err_r);
    ediff = ESUM_W'(err) - ESUM_W'(last_err_r);

    i_prod = 31'($signed({1'b0, ki_r})) * 31'(esum);
    p_prod = 31'($signed({1'b0, kp_r})) * 31'(err);
    d_prod = 32'($signed({1'b0, kd_r})) * 32'(ediff);
    pd_sum = 32'(p_prod) + d_prod;

    // Trapezoidal integral, clamped
    integ_raw = 24'(int_sum_r) + 24'(i_prod >>> 8);
    ilim_s    = $signed({9'b0, ilim_r});
    if (integ_raw > ilim_s) begin
      integ_nxt = INTEG_W'(ilim_s);
    end else if (integ_raw < -ilim_s) begin
      integ_nxt = INTEG_W'(-ilim_s);
    end else begin
      integ_nxt = INTEG_W'(integ_raw);
    end

    eff_raw = 25'(pd_sum >>> 8) + 25'(integ_nxt);
    elim_s  = $signed({10'b0, elim_r});
    if (eff_raw > elim_s) begin
      eff_nxt = EFFORT_W'(elim_s);
    end else if (eff_raw < -elim_s) begin
      eff_nxt = EFFORT_W'(-elim_s);
    end else begin
      eff_nxt = EFFORT_W'(eff_raw);
    end

    dsum = (18'(eff_nxt) <<< 1) + DUTY_BIAS;
    dq   = dsum >>> 10;
    if (dq < 18'sd0) begin
      duty_nxt = '0;
    end else if (dq > 18'($signed({1'b0, DUTY_MAX}))) begin
      duty_nxt = DUTY_MAX;
    end else begin
      duty_nxt = dq[DUTY_W-1:0];
    end

    // Hundredths, truncated toward zero
    cprod     = 20'(meas) * CENTI_SCALE;
    cadj      = (cprod < 20'sd0) ? cprod + Q10_ROUND : cprod;
    cq        = cadj >>> 10;
    centi_nxt = cq[CENTI_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= PROP_GAIN_RST;
      ki_r   <= INTEG_GAIN_RST;
      kd_r   <= DERIV_GAIN_RST;
      ilim_r <= INTEG_LIMIT_RST;
      elim_r <= EFFORT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROP_GAIN:    kp_r   <= cfg_data;
        REG_INTEG_GAIN:   ki_r   <= cfg_data;
        REG_DERIV_GAIN:   kd_r   <= cfg_data;
        REG_INTEG_LIMIT:  ilim_r <= cfg_data[LIMIT_W-1:0];
        REG_EFFORT_LIMIT: elim_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      last_err_r  <= '0;
      int_sum_r   <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s_valid_r <= 1'b1;
      end else if (adv) begin
        s_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        last_err_r  <= err;
        int_sum_r   <= integ_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      adc_r <= in_adc_sample;
      sp_r  <= in_setpoint;
    end
    if (adv) begin
      duty_r  <= duty_nxt;
      centi_r <= centi_nxt;
      eff_r   <= eff_nxt;
    end
  end

  // Controller state moves only when an item enters the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(last_err_r) && $stable(int_sum_r)))
    else $error("controller state changed without an item advancing");

  // A waiting item drops into an empty result register
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (s_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("input stage did not advance into empty result register");

  // Duty side of midpoint follows effort sign
  a_duty_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !eff_r[EFFORT_W-1]) |-> (duty_r >= DUTY_MID && duty_r <= DUTY_MAX))
    else $error("non-negative effort gave duty below midpoint");

  a_duty_neg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && eff_r[EFFORT_W-1]) |-> (duty_r < DUTY_MID))
    else $error("negative effort gave duty at or above midpoint");

endmodule
`default_nettype wire
